@@ rtl/core/segm_pkg.sv @@
`default_nettype none

package segm_pkg;

    // field and state widths
    localparam int unsigned LEN_W  = 32;
    localparam int unsigned SYM_W  = 32;
    localparam int unsigned GAP_W  = 9;
    localparam int unsigned LIM_W  = 8;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned ADDR_W = 4;

    // register reset values
    localparam logic [SYM_W-1:0] MARKER_A_RST  = SYM_W'(0);
    localparam logic [SYM_W-1:0] MARKER_B_RST  = SYM_W'(1);
    localparam logic [LIM_W-1:0] GAP_LIMIT_RST = LIM_W'(20);

    // result queue depth
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

    // register index codes
    typedef enum logic [1:0] {
        REG_MARKER_A  = 2'd0,
        REG_MARKER_B  = 2'd1,
        REG_GAP_LIMIT = 2'd2
    } t_reg_idx;

    // one or two results caused by a single symbol
    typedef struct packed {
        logic             two;
        logic [LEN_W-1:0] len0;
        logic             fin0;
        logic [LEN_W-1:0] len1;
        logic             fin1;
    } t_res_pair;

endpackage

`default_nettype wire

@@ rtl/core/segm_front.sv @@
`default_nettype none

module segm_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // config port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [segm_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [segm_pkg::DATA_W-1:0]  pwdata,
    output logic      [segm_pkg::DATA_W-1:0]  prdata,
    // symbol channel
    input  wire logic                         i_valid,
    input  wire logic [segm_pkg::SYM_W-1:0]   i_symbol,
    input  wire logic                         i_end_of_stream,
    output logic                              o_stall,
    // queue push side
    input  wire logic                         i_q_full,
    output logic                              o_push,
    output segm_pkg::t_res_pair               o_entry
);

    logic [segm_pkg::SYM_W-1:0] r_marker_a;
    logic [segm_pkg::SYM_W-1:0] r_marker_b;
    logic [segm_pkg::LIM_W-1:0] r_gap_limit;

    logic [segm_pkg::LEN_W-1:0] r_len, n_len;
    logic [segm_pkg::GAP_W-1:0] r_gap, n_gap;
    logic                       r_seen, n_seen;

    logic                       accept;
    logic                       cfg_wr;
    segm_pkg::t_reg_idx         reg_idx;
    logic                       is_mk;
    logic [segm_pkg::GAP_W:0]   gap_inc;
    logic [segm_pkg::GAP_W:0]   add_inc;
    logic [segm_pkg::LEN_W:0]   sum;
    logic [segm_pkg::LEN_W-1:0] sat_len;
    logic                       ovf;
    logic                       n_res;
    segm_pkg::t_res_pair        entry;

    assign reg_idx = segm_pkg::t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel & penable & pwrite;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marker_a  <= segm_pkg::MARKER_A_RST;
            r_marker_b  <= segm_pkg::MARKER_B_RST;
            r_gap_limit <= segm_pkg::GAP_LIMIT_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                segm_pkg::REG_MARKER_A:  r_marker_a  <= pwdata[segm_pkg::SYM_W-1:0];
                segm_pkg::REG_MARKER_B:  r_marker_b  <= pwdata[segm_pkg::SYM_W-1:0];
                segm_pkg::REG_GAP_LIMIT: r_gap_limit <= pwdata[segm_pkg::LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (reg_idx)
            segm_pkg::REG_MARKER_A:  prdata = segm_pkg::DATA_W'(r_marker_a);
            segm_pkg::REG_MARKER_B:  prdata = segm_pkg::DATA_W'(r_marker_b);
            segm_pkg::REG_GAP_LIMIT: prdata = segm_pkg::DATA_W'(r_gap_limit);
            default:                 prdata = '0;
        endcase
    end

    assign accept  = i_valid & ~i_q_full;
    assign o_stall = i_q_full;

    // marker classification and saturating length add
    assign is_mk   = (i_symbol == r_marker_a) || (i_symbol == r_marker_b);
    assign gap_inc = {1'b0, r_gap} + (segm_pkg::GAP_W+1)'(1);
    assign add_inc = r_seen ? gap_inc : (segm_pkg::GAP_W+1)'(1);
    assign sum     = {1'b0, r_len} + (segm_pkg::LEN_W+1)'(add_inc);
    assign sat_len = sum[segm_pkg::LEN_W] ? '1 : sum[segm_pkg::LEN_W-1:0];

    // block state update and results of this symbol
    always_comb begin
        n_len = r_len;
        n_gap = r_gap;
        n_seen = r_seen;
        ovf = 1'b0;
        n_res = 1'b0;
        entry = '0;

        if (!r_seen) begin
            n_len = sat_len;
            if (is_mk) begin
                n_seen = 1'b1;
                n_gap  = '0;
            end
        end else if (is_mk) begin
            n_len = sat_len;
            n_gap = '0;
        end else if (gap_inc > (segm_pkg::GAP_W+1)'(r_gap_limit)) begin
            // gap too long: close block, gap symbols open the next one
            ovf    = 1'b1;
            n_len  = segm_pkg::LEN_W'(gap_inc);
            n_gap  = '0;
            n_seen = 1'b0;
        end else begin
            n_gap = gap_inc[segm_pkg::GAP_W-1:0];
        end

        if (ovf) begin
            n_res      = 1'b1;
            entry.len0 = r_len;
            entry.fin0 = 1'b0;
            if (i_end_of_stream) begin
                entry.two  = 1'b1;
                entry.len1 = n_len;
                entry.fin1 = 1'b1;
            end
        end else if (i_end_of_stream) begin
            n_res = 1'b1;
            if (n_seen && (n_gap != '0)) begin
                entry.two  = 1'b1;
                entry.len0 = n_len;
                entry.fin0 = 1'b0;
                entry.len1 = segm_pkg::LEN_W'(n_gap);
                entry.fin1 = 1'b1;
            end else begin
                entry.len0 = n_len;
                entry.fin0 = 1'b1;
            end
        end

        // stream ends: start over
        if (i_end_of_stream) begin
            n_len  = '0;
            n_gap  = '0;
            n_seen = 1'b0;
        end
    end

    // block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_gap  <= '0;
            r_seen <= 1'b0;
        end else if (accept) begin
            r_len  <= n_len;
            r_gap  <= n_gap;
            r_seen <= n_seen;
        end
    end

    assign o_push  = accept & n_res;
    assign o_entry = entry;

endmodule

`default_nettype wire

@@ rtl/core/segm_fifo.sv @@
`default_nettype none

module segm_fifo (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire segm_pkg::t_res_pair i_data,
    input  wire logic                i_pop,
    output segm_pkg::t_res_pair      o_data,
    output logic                     o_full,
    output logic                     o_empty
);

    segm_pkg::t_res_pair                r_mem [segm_pkg::FIFO_DEPTH];
    logic [segm_pkg::FIFO_AW-1:0]       r_wr_ptr;
    logic [segm_pkg::FIFO_AW-1:0]       r_rd_ptr;
    logic [segm_pkg::FIFO_AW:0]         r_count;
    logic                               do_pop;

    assign o_full  = (r_count == (segm_pkg::FIFO_AW+1)'(segm_pkg::FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_pop  = i_pop & ~o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + segm_pkg::FIFO_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + segm_pkg::FIFO_AW'(1);
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + (segm_pkg::FIFO_AW+1)'(1);
                2'b01:   r_count <= r_count - (segm_pkg::FIFO_AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/segm_back.sv @@
`default_nettype none

module segm_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // queue pop side
    input  wire segm_pkg::t_res_pair        i_entry,
    input  wire logic                       i_q_empty,
    output logic                            o_pop,
    // result channel
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic [segm_pkg::LEN_W-1:0]      o_blk_len,
    output logic                            o_final_block,
    output logic                            o_last_of_run
);

    logic                       r_valid;
    logic                       r_phase;
    logic [segm_pkg::LEN_W-1:0] r_len;
    logic                       r_fin;
    logic                       r_last;
    logic                       load;

    // output register free or being drained
    assign load  = ~i_q_empty & (~r_valid | ~i_stall);
    assign o_pop = load & (r_phase | ~i_entry.two);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_phase <= ~r_phase & i_entry.two;
            end else if (~i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_phase) begin
                r_len  <= i_entry.len1;
                r_fin  <= i_entry.fin1;
                r_last <= 1'b1;
            end else begin
                r_len  <= i_entry.len0;
                r_fin  <= i_entry.fin0;
                r_last <= ~i_entry.two;
            end
        end
    end

    assign o_valid        = r_valid;
    assign o_blk_len      = r_len;
    assign o_final_block  = r_fin;
    assign o_last_of_run  = r_last;

endmodule

`default_nettype wire

@@ rtl/core/rare_marker_block_segmenter.sv @@
// a result passes through the result queue and the output register; the second result
//   of a pair (stream end with pending gap or gap overflow) follows the first
// throughput: one symbol per cycle unless the input stalls; results leave at one per
//   cycle unless the output stalls
// a 4-entry result queue absorbs output stalls; input stalls only when it is full
// reset: synchronous, active low; clears block state and queue, loads register defaults
`default_nettype none

module rare_marker_block_segmenter (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // config port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [segm_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [segm_pkg::DATA_W-1:0]  pwdata,
    output logic      [segm_pkg::DATA_W-1:0]  prdata,
    output logic                              pready,
    // symbol channel
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [segm_pkg::SYM_W-1:0]   i_symbol,
    input  wire logic                         i_end_of_stream,
    // result channel
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [segm_pkg::LEN_W-1:0]        o_blk_len,
    output logic                              o_final_block,
    output logic                              o_last_of_run
);

    logic                q_full;
    logic                q_empty;
    logic                q_push;
    logic                q_pop;
    segm_pkg::t_res_pair q_wdata;
    segm_pkg::t_res_pair q_rdata;

    assign pready = 1'b1;

    // classify symbols and track blocks
    segm_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .i_valid         (i_in_valid),
        .i_symbol        (i_symbol),
        .i_end_of_stream (i_end_of_stream),
        .o_stall         (o_in_stall),
        .i_q_full        (q_full),
        .o_push          (q_push),
        .o_entry         (q_wdata)
    );

    // result queue
    segm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // serialize results to the output
    segm_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_entry        (q_rdata),
        .i_q_empty      (q_empty),
        .o_pop          (q_pop),
        .o_valid        (o_out_valid),
        .i_stall        (i_out_stall),
        .o_blk_len      (o_blk_len),
        .o_final_block  (o_final_block),
        .o_last_of_run  (o_last_of_run)
    );

endmodule

`default_nettype wire

@@ dv/tb_rare_marker_block_segmenter.sv @@
module tb_rare_marker_block_segmenter;
    timeunit 1ns;
    timeprecision 1ps;

    // one symbol transfer and one block result
    typedef struct packed {
        logic [segm_pkg::SYM_W-1:0] sym;
        logic                       eos;
    } t_sym_item;

    typedef struct packed {
        logic [segm_pkg::LEN_W-1:0] len;
        logic                       fin;
        logic                       last;
    } t_block_result;

    logic                          i_clk;
    logic                          i_rst_n = 1'b0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [segm_pkg::ADDR_W-1:0]   paddr = '0;
    logic [segm_pkg::DATA_W-1:0]   pwdata = '0;
    logic [segm_pkg::DATA_W-1:0]   prdata;
    logic                          pready;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    logic [segm_pkg::SYM_W-1:0]    i_symbol = '0;
    logic                          i_end_of_stream = 1'b0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic [segm_pkg::LEN_W-1:0]    o_blk_len;
    logic                          o_final_block;
    logic                          o_last_of_run;

    rare_marker_block_segmenter DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_symbol        (i_symbol),
        .i_end_of_stream (i_end_of_stream),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_blk_len       (o_blk_len),
        .o_final_block   (o_final_block),
        .o_last_of_run   (o_last_of_run)
    );

    // symbols waiting to be sent and block lengths waiting to come out
    t_sym_item     symbols_pending[$];
    t_block_result blocks_due[$];

    // shadow of the configuration registers
    logic [segm_pkg::SYM_W-1:0] cfg_marker_a = segm_pkg::MARKER_A_RST;
    logic [segm_pkg::SYM_W-1:0] cfg_marker_b = segm_pkg::MARKER_B_RST;
    logic [segm_pkg::LIM_W-1:0] cfg_gap_limit = segm_pkg::GAP_LIMIT_RST;

    // shadow of the open block
    logic [segm_pkg::LEN_W-1:0] open_len = '0;
    logic [segm_pkg::GAP_W-1:0] gap_run = '0;
    logic                       open_has_marker = 1'b0;

    int  mismatches = 0;
    bit  sym_taken = 1'b0;
    int  send_idle_left = 0;
    int  send_calm_left = 0;
    bit  sender_eager = 1'b0;
    int  out_hold_left = 0;
    int  recv_calm_left = 0;
    int  choke_requests = 0;
    int  chokes_served = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        if (mismatches <= 100)
            $display("%0t ns mismatch %s: got %0h want %0h", $time, what, got, want);
    endtask

    function automatic bit hits_marker(logic [segm_pkg::SYM_W-1:0] s);
        return (s == cfg_marker_a) || (s == cfg_marker_b);
    endfunction

    function automatic logic [segm_pkg::LEN_W-1:0] len_add(logic [segm_pkg::LEN_W-1:0] a,
                                                           logic [segm_pkg::LEN_W-1:0] b);
        logic [segm_pkg::LEN_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[segm_pkg::LEN_W] ? '1 : s[segm_pkg::LEN_W-1:0];
    endfunction

    // advance the open block by one symbol and queue the block lengths it closes
    function automatic void segment_symbol(logic [segm_pkg::SYM_W-1:0] s, logic eos);
        t_block_result res[2];
        int            n;
        bit            mk;
        n = 0;
        mk = hits_marker(s);
        if (!open_has_marker) begin
            open_len = len_add(open_len, segm_pkg::LEN_W'(1));
            if (mk) begin
                open_has_marker = 1'b1;
                gap_run = '0;
            end
        end else if (mk) begin
            // gap merges into the block
            open_len = len_add(open_len, segm_pkg::LEN_W'(gap_run) + segm_pkg::LEN_W'(1));
            gap_run = '0;
        end else begin
            gap_run = gap_run + segm_pkg::GAP_W'(1);
            if (gap_run > segm_pkg::GAP_W'(cfg_gap_limit)) begin
                // gap too long: close the block, the gap opens the next one
                res[n] = '{open_len, 1'b0, 1'b0};
                n++;
                open_len = segm_pkg::LEN_W'(gap_run);
                gap_run = '0;
                open_has_marker = 1'b0;
            end
        end
        if (eos) begin
            if (open_has_marker && gap_run != 0) begin
                res[n] = '{open_len, 1'b0, 1'b0};
                n++;
                res[n] = '{segm_pkg::LEN_W'(gap_run), 1'b1, 1'b0};
                n++;
            end else begin
                res[n] = '{open_len, 1'b1, 1'b0};
                n++;
            end
            open_len = '0;
            gap_run = '0;
            open_has_marker = 1'b0;
        end
        if (n > 0)
            res[n-1].last = 1'b1;
        for (int k = 0; k < n; k++)
            blocks_due.push_back(res[k]);
    endfunction

    // symbol sender
    always @(negedge i_clk) begin : drive_symbols
        t_sym_item nxt;
        int        r;
        if (!i_in_valid || sym_taken) begin
            if (send_idle_left > 0 && !sender_eager) begin
                send_idle_left--;
                i_in_valid <= 1'b0;
            end else if (symbols_pending.size() > 0) begin
                nxt = symbols_pending.pop_front();
                i_in_valid <= 1'b1;
                i_symbol <= nxt.sym;
                i_end_of_stream <= nxt.eos;
                // idle after this transfer
                send_idle_left = 0;
                if (send_calm_left > 0) begin
                    send_calm_left--;
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 2)
                        send_calm_left = $urandom_range(20, 80);
                    else if (r < 62)
                        send_idle_left = 0;
                    else if (r < 88)
                        send_idle_left = $urandom_range(1, 3);
                    else if (r < 97)
                        send_idle_left = $urandom_range(4, 12);
                    else
                        send_idle_left = $urandom_range(20, 60);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result receiver stall
    always @(negedge i_clk) begin : drive_result_stall
        int r;
        if (chokes_served != choke_requests) begin
            // long hold so the result queue fills and the input backs up
            chokes_served++;
            out_hold_left = 80;
        end
        if (out_hold_left > 0) begin
            out_hold_left--;
            i_out_stall <= 1'b1;
        end else if (recv_calm_left > 0) begin
            recv_calm_left--;
            i_out_stall <= 1'b0;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 2)
                recv_calm_left = $urandom_range(20, 80);
            else if (r < 27)
                out_hold_left = $urandom_range(1, 3);
            else if (r < 33)
                out_hold_left = $urandom_range(4, 12);
            else if (r < 35)
                out_hold_left = $urandom_range(20, 40);
            i_out_stall <= (out_hold_left > 0);
            if (out_hold_left > 0)
                out_hold_left--;
        end
    end

    // predict on each symbol transfer, check each result transfer
    always @(posedge i_clk) begin : watch_ports
        t_block_result want;
        sym_taken = i_rst_n && i_in_valid && !o_in_stall;
        if (sym_taken)
            segment_symbol(i_symbol, i_end_of_stream);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (blocks_due.size() == 0) begin
                report_mismatch("unexpected block", o_blk_len, '0);
            end else begin
                want = blocks_due.pop_front();
                if (o_blk_len !== want.len)
                    report_mismatch("blk_len", o_blk_len, want.len);
                if (o_final_block !== want.fin)
                    report_mismatch("final_block", 32'(o_final_block), 32'(want.fin));
                if (o_last_of_run !== want.last)
                    report_mismatch("last_of_run", 32'(o_last_of_run), 32'(want.last));
            end
        end
    end

    // register write, then read back
    task automatic cfg_write(segm_pkg::t_reg_idx idx, logic [segm_pkg::DATA_W-1:0] val);
        logic [segm_pkg::DATA_W-1:0] rd;
        logic [segm_pkg::DATA_W-1:0] want;
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            segm_pkg::REG_MARKER_A:  cfg_marker_a = val;
            segm_pkg::REG_MARKER_B:  cfg_marker_b = val;
            segm_pkg::REG_GAP_LIMIT: cfg_gap_limit = val[segm_pkg::LIM_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        psel <= 1'b1;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rd = prdata;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        want = val;
        if (idx == segm_pkg::REG_GAP_LIMIT) begin
            rd = {{(segm_pkg::DATA_W-segm_pkg::LIM_W){1'b0}}, rd[segm_pkg::LIM_W-1:0]};
            want = {{(segm_pkg::DATA_W-segm_pkg::LIM_W){1'b0}}, val[segm_pkg::LIM_W-1:0]};
        end
        if (rd !== want)
            report_mismatch("register read", rd, want);
    endtask

    // non-marker symbol, often one bit away from a marker
    function automatic logic [segm_pkg::SYM_W-1:0] plain_symbol();
        logic [segm_pkg::SYM_W-1:0] s;
        s = cfg_marker_a;
        while (hits_marker(s)) begin
            if ($urandom_range(0, 4) == 0)
                s = ($urandom_range(0, 1) ? cfg_marker_a : cfg_marker_b)
                    ^ (32'h1 << $urandom_range(0, segm_pkg::SYM_W - 1));
            else
                s = $urandom;
        end
        return s;
    endfunction

    // marker runs with gaps around the limit, plus some noise
    task automatic queue_random_stream(int count);
        int pushed;
        int gap;
        int lim;
        pushed = 0;
        lim = cfg_gap_limit;
        while (pushed < count) begin
            if ($urandom_range(0, 99) < 85) begin
                repeat ($urandom_range(1, 3)) begin
                    symbols_pending.push_back('{$urandom_range(0, 1) ? cfg_marker_a : cfg_marker_b,
                                                $urandom_range(0, 99) < 2});
                    pushed++;
                end
                case ($urandom_range(0, 3))
                    0: gap = lim;
                    1: gap = lim + 1;
                    2: gap = $urandom_range(0, lim > 4 ? 4 : lim);
                    default: gap = $urandom_range(0, lim + 2);
                endcase
                repeat (gap) begin
                    symbols_pending.push_back('{plain_symbol(), $urandom_range(0, 99) < 2});
                    pushed++;
                end
                // sometimes end the stream right here
                if ($urandom_range(0, 9) == 0)
                    symbols_pending[symbols_pending.size()-1].eos = 1'b1;
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    symbols_pending.push_back('{$urandom_range(0, 2) == 0 ?
                                                ($urandom_range(0, 1) ? cfg_marker_a : cfg_marker_b) :
                                                segm_pkg::SYM_W'($urandom),
                                                $urandom_range(0, 99) < 5});
                    pushed++;
                end
            end
        end
    endtask

    // wait until every symbol is sent and every block has come out
    task automatic drain();
        while (symbols_pending.size() != 0 || i_in_valid) @(posedge i_clk);
        while (blocks_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic run_phase(logic [31:0] mark_a, logic [31:0] mark_b, logic [7:0] limit,
                             int count, bit choke);
        logic [segm_pkg::DATA_W-1:0] limit_word;
        limit_word = $urandom;
        limit_word[segm_pkg::LIM_W-1:0] = limit;
        cfg_write(segm_pkg::REG_MARKER_A, mark_a);
        cfg_write(segm_pkg::REG_MARKER_B, mark_b);
        cfg_write(segm_pkg::REG_GAP_LIMIT, limit_word);
        sender_eager = choke;
        queue_random_stream(count);
        if (choke)
            choke_requests++;
        drain();
        sender_eager = 1'b0;
    endtask

    // main sequence
    initial begin : main_sequence
        logic [31:0] x;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: default markers 0 and 1, short gap limit
        cfg_write(segm_pkg::REG_GAP_LIMIT, 32'd2);
        // merge within limit, then gap overflow
        symbols_pending.push_back('{32'h0000_0000, 1'b0});
        symbols_pending.push_back('{32'hFFFF_FFFF, 1'b0});
        symbols_pending.push_back('{32'h0000_0001, 1'b0});
        symbols_pending.push_back('{32'hFFFF_FFFE, 1'b0});
        symbols_pending.push_back('{32'h0000_0002, 1'b0});
        symbols_pending.push_back('{32'h8000_0000, 1'b0});
        // plain end of stream
        symbols_pending.push_back('{32'h0000_0000, 1'b1});
        symbols_pending.push_back('{32'h7FFF_FFFF, 1'b1});
        // end with pending gap
        symbols_pending.push_back('{32'h0000_0001, 1'b0});
        symbols_pending.push_back('{32'h0000_0003, 1'b0});
        symbols_pending.push_back('{32'hFFFF_FFFF, 1'b1});
        // overflow on the last symbol
        symbols_pending.push_back('{32'h0000_0000, 1'b0});
        symbols_pending.push_back('{32'h0000_0004, 1'b0});
        symbols_pending.push_back('{32'h0000_0005, 1'b0});
        symbols_pending.push_back('{32'h0000_0006, 1'b1});
        // single marker stream, then a block that starts without a marker
        symbols_pending.push_back('{32'h0000_0001, 1'b1});
        symbols_pending.push_back('{32'h5555_5555, 1'b0});
        symbols_pending.push_back('{32'hAAAA_AAAA, 1'b0});
        symbols_pending.push_back('{32'h0000_0000, 1'b0});
        symbols_pending.push_back('{32'h0000_0001, 1'b1});
        drain();

        // random phases over several register settings
        run_phase(32'hFFFF_FFFF, 32'h0000_0000, 8'd0, 250, 1'b1);
        run_phase($urandom, $urandom, 8'd255, 400, 1'b0);
        x = $urandom;
        run_phase(x, x, 8'($urandom_range(1, 30)), 300, 1'b0);
        run_phase($urandom, $urandom, 8'd20, 350, 1'b1);
        x = $urandom;
        run_phase(x, x ^ 32'h8000_0000, 8'($urandom_range(0, 8)), 300, 1'b0);
        run_phase($urandom, $urandom, 8'($urandom_range(0, 40)), 300, 1'b0);

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
